// ===== hdl/lpm_pkg.sv =====
// lpm_pkg: shared types, constants and helpers for the route lookup block
// no dependencies; used by longest_prefix_match_lookup

package lpm_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEN_W   = 6;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot_index;
    logic        slot_valid;
    logic [31:0] route_dest_in;
    logic [31:0] route_mask_in;
    logic [31:0] route_gateway_in;
    logic [3:0]  route_iface_in;
    logic [31:0] lookup_addr;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] match_dest;
    logic [31:0] match_mask;
    logic [31:0] match_gateway;
    logic [3:0]  match_iface;
  } out_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [3:0]  iface;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  // prefix length of a mask, parallel bit count
  function automatic logic [LEN_W-1:0] ones_in(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0f0f_0f0f;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[LEN_W-1:0];
  endfunction

endpackage

// ===== hdl/longest_prefix_match_lookup.sv =====
// longest_prefix_match_lookup: ipv4 route table with longest prefix match search
// depends on lpm_pkg and lpm_ram
//
// A write transfer (kind 0) loads a route into a slot or clears the slot's
// valid bit, and gives no result. A lookup transfer (kind 1) scans every
// slot, one per cycle through the single read port of the route ram, and its
// result is loaded into the output register from the done state, after which
// the next item can follow; the input side stalls during the scan, and also
// while a finished scan waits for the output register to free up. The chosen
// route is the matching valid slot with the longest mask, the lowest slot on
// a tie; a zero mask matches every address. The output register holds a
// finished result, so the next item is taken while that result still waits.
// Valid bits clear at reset; route contents need no clearing pass.

module longest_prefix_match_lookup (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lpm_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output lpm_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);

  lpm_pkg::state_e state_q, state_d;

  logic [lpm_pkg::ENTRIES-1:0] valid_q;
  logic [lpm_pkg::IDX_W-1:0]   cnt_q;
  logic [31:0]                 addr_q;
  logic                        eval_q;
  logic                        vld_rd_q;
  logic                        found_q;
  logic [lpm_pkg::LEN_W-1:0]   best_len_q;
  lpm_pkg::route_t             best_q;
  lpm_pkg::out_t               out_q;
  logic                        out_valid_q;

  logic                        in_xfer;
  logic                        wr_take;
  logic                        wr_in_range;
  logic [lpm_pkg::IDX_W-1:0]   wr_addr;
  logic                        ram_we;
  logic [lpm_pkg::ROUTE_W-1:0] ram_rdata;
  lpm_pkg::route_t             wr_route;
  lpm_pkg::route_t             rd_route;
  logic                        start;
  logic                        cnt_last;
  logic                        load_out;
  logic                        slot_hit;
  logic [lpm_pkg::LEN_W-1:0]   slot_len;
  logic                        take;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign wr_in_range = 32'(in_i.slot_index) < lpm_pkg::ENTRIES;
  assign wr_addr     = lpm_pkg::IDX_W'(in_i.slot_index);
  assign wr_take     = in_xfer && (in_i.kind == lpm_pkg::KIND_WRITE) && wr_in_range;
  assign ram_we      = wr_take && in_i.slot_valid;
  assign cnt_last    = cnt_q == lpm_pkg::IDX_W'(lpm_pkg::ENTRIES - 1);

  assign wr_route.dest    = in_i.route_dest_in;
  assign wr_route.mask    = in_i.route_mask_in;
  assign wr_route.gateway = in_i.route_gateway_in;
  assign wr_route.iface   = in_i.route_iface_in;

  lpm_ram #(
    .WIDTH (lpm_pkg::ROUTE_W),
    .DEPTH (lpm_pkg::ENTRIES)
  ) u_route_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_route),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  assign rd_route = lpm_pkg::route_t'(ram_rdata);
  assign slot_len = lpm_pkg::ones_in(rd_route.mask);
  assign slot_hit = eval_q && vld_rd_q &&
                    ((addr_q & rd_route.mask) == (rd_route.dest & rd_route.mask));
  assign take     = slot_hit && (!found_q || (slot_len > best_len_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpm_pkg::ST_IDLE: begin
        if (in_valid_i && (in_i.kind == lpm_pkg::KIND_LOOKUP)) begin
          state_d = lpm_pkg::ST_SCAN;
        end
      end
      lpm_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_d = lpm_pkg::ST_LAST;
        end
      end
      lpm_pkg::ST_LAST: begin
        state_d = lpm_pkg::ST_DONE;
      end
      lpm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = lpm_pkg::ST_IDLE;
        end
      end
      default: state_d = lpm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    start      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      lpm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        start      = in_valid_i && (in_i.kind == lpm_pkg::KIND_LOOKUP);
      end
      lpm_pkg::ST_SCAN, lpm_pkg::ST_LAST: begin
        in_stall_o = 1'b1;
      end
      lpm_pkg::ST_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpm_pkg::ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      vld_rd_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_take) begin
        valid_q[wr_addr] <= in_i.slot_valid;
      end
      if (start) begin
        cnt_q <= '0;
      end else if (state_q == lpm_pkg::ST_SCAN && !cnt_last) begin
        cnt_q <= cnt_q + 1'b1;
      end
      eval_q   <= state_q == lpm_pkg::ST_SCAN;
      vld_rd_q <= valid_q[cnt_q];
      if (start) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      addr_q <= in_i.lookup_addr;
    end
    if (take) begin
      best_q     <= rd_route;
      best_len_q <= slot_len;
    end
    if (load_out) begin
      out_q.hit           <= found_q;
      out_q.match_dest    <= found_q ? best_q.dest : '0;
      out_q.match_mask    <= found_q ? best_q.mask : '0;
      out_q.match_gateway <= found_q ? best_q.gateway : '0;
      out_q.match_iface   <= found_q ? best_q.iface : '0;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_lookup_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.kind == lpm_pkg::KIND_LOOKUP)
      |=> (state_q == lpm_pkg::ST_SCAN) && (cnt_q == '0))
    else $error("lookup transfer did not start a scan from slot zero");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(wr_addr)])
    else $error("route write did not set the slot valid bit");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == lpm_pkg::ST_DONE)
    else $error("result appeared without a finished scan");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.hit
      |-> (out_o.match_dest == '0) && (out_o.match_mask == '0) &&
          (out_o.match_gateway == '0) && (out_o.match_iface == '0))
    else $error("miss result carries nonzero route fields");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q |-> (state_q == lpm_pkg::ST_SCAN) || (state_q == lpm_pkg::ST_LAST))
    else $error("slot evaluated outside of a scan");

endmodule

// ===== hdl/lpm_ram.sv =====
// lpm_ram: generic single write port, single read port ram, registered read
// no dependencies

module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/tb_longest_prefix_match_lookup.sv =====
`timescale 1ns / 1ps
// tb_longest_prefix_match_lookup: self-checking bench for the ipv4 route lookup block
// drives route writes and lookups with random gaps and stalls, predicts each lookup
// from a local route table; depends on lpm_pkg and longest_prefix_match_lookup

module tb_longest_prefix_match_lookup;

  localparam int TOTAL_ITEMS  = 1450;
  localparam int MAX_WAIT     = 18;
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AT      = 40;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 100;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  lpm_pkg::in_t  in_i        = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  lpm_pkg::out_t out_o;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;

  lpm_pkg::in_t  pending_q[$];
  lpm_pkg::out_t expected_routes[$];

  lpm_pkg::route_t route_table[lpm_pkg::ENTRIES];
  bit              route_live[lpm_pkg::ENTRIES];
  logic [31:0]     plan_dest[lpm_pkg::ENTRIES];
  logic [31:0]     plan_mask[lpm_pkg::ENTRIES];
  bit              plan_live[lpm_pkg::ENTRIES];

  int total_items  = 0;
  int tx_wait      = 0;
  int tx_cnt       = 0;
  int rx_hold      = 0;
  int rx_cnt       = 0;
  int idle_cycles  = 0;
  int mismatch_cnt = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  longest_prefix_match_lookup DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: wrong %s, got %h, want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // route table update on a write, longest prefix search on a lookup
  task automatic route_table_apply(input lpm_pkg::in_t it);
    lpm_pkg::out_t res;
    int            best_len;
    int            len;
    bit            found;
    res      = '0;
    found    = 1'b0;
    best_len = 0;
    if (it.kind == lpm_pkg::KIND_WRITE) begin
      if (it.slot_index < lpm_pkg::ENTRIES) begin
        if (it.slot_valid) begin
          route_table[it.slot_index].dest    = it.route_dest_in;
          route_table[it.slot_index].mask    = it.route_mask_in;
          route_table[it.slot_index].gateway = it.route_gateway_in;
          route_table[it.slot_index].iface   = it.route_iface_in;
          route_live[it.slot_index] = 1'b1;
        end else begin
          route_live[it.slot_index] = 1'b0;
        end
      end
    end else begin
      for (int i = 0; i < lpm_pkg::ENTRIES; i++) begin
        if (route_live[i] && ((it.lookup_addr & route_table[i].mask) ==
                              (route_table[i].dest & route_table[i].mask))) begin
          len = $countones(route_table[i].mask);
          if (!found || len > best_len) begin
            found             = 1'b1;
            best_len          = len;
            res.hit           = 1'b1;
            res.match_dest    = route_table[i].dest;
            res.match_mask    = route_table[i].mask;
            res.match_gateway = route_table[i].gateway;
            res.match_iface   = route_table[i].iface;
          end
        end
      end
      expected_routes = {expected_routes, res};
    end
  endtask

  task automatic check_result(input lpm_pkg::out_t got);
    lpm_pkg::out_t want;
    if (expected_routes.size() == 0) begin
      report_mismatch("result with no lookup pending, dest", got.match_dest, 32'h0);
    end else begin
      want = expected_routes.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.match_dest !== want.match_dest)
        report_mismatch("match_dest", got.match_dest, want.match_dest);
      if (got.match_mask !== want.match_mask)
        report_mismatch("match_mask", got.match_mask, want.match_mask);
      if (got.match_gateway !== want.match_gateway)
        report_mismatch("match_gateway", got.match_gateway, want.match_gateway);
      if (got.match_iface !== want.match_iface)
        report_mismatch("match_iface", 32'(got.match_iface), 32'(want.match_iface));
    end
  endtask

  task automatic push_item(input lpm_pkg::in_t it);
    if (it.kind == lpm_pkg::KIND_WRITE && it.slot_index < lpm_pkg::ENTRIES) begin
      plan_live[it.slot_index] = it.slot_valid;
      if (it.slot_valid) begin
        plan_dest[it.slot_index] = it.route_dest_in;
        plan_mask[it.slot_index] = it.route_mask_in;
      end
    end
    pending_q = {pending_q, it};
  endtask

  task automatic push_write(input logic [5:0] slot, input logic keep,
                            input logic [31:0] dest, input logic [31:0] mask,
                            input logic [31:0] gateway, input logic [3:0] iface);
    lpm_pkg::in_t it;
    it.kind             = lpm_pkg::KIND_WRITE;
    it.slot_index       = slot;
    it.slot_valid       = keep;
    it.route_dest_in    = dest;
    it.route_mask_in    = mask;
    it.route_gateway_in = gateway;
    it.route_iface_in   = iface;
    it.lookup_addr      = $urandom();
    push_item(it);
  endtask

  task automatic push_lookup(input logic [31:0] addr);
    lpm_pkg::in_t it;
    it.kind             = lpm_pkg::KIND_LOOKUP;
    it.slot_index       = 6'($urandom_range(0, 63));
    it.slot_valid       = 1'($urandom_range(0, 1));
    it.route_dest_in    = $urandom();
    it.route_mask_in    = $urandom();
    it.route_gateway_in = $urandom();
    it.route_iface_in   = 4'($urandom_range(0, 15));
    it.lookup_addr      = addr;
    push_item(it);
  endtask

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
  endfunction

  function automatic logic [31:0] random_mask();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom();
    if (pick < 16) return 32'h0;
    if (pick < 25) return prefix_mask($urandom_range(1, 7));
    return prefix_mask($urandom_range(8, 32));
  endfunction

  function automatic int pick_live_slot();
    int s;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(0, lpm_pkg::ENTRIES - 1);
      if (plan_live[s]) return s;
    end
    return -1;
  endfunction

  initial begin : main
    lpm_pkg::in_t it;
    int           pick;
    int           s;
    int           base;
    logic [31:0]  addr;
    logic [31:0]  dest;
    logic [31:0]  mask;

    // empty table
    push_lookup(32'h0000_0000);
    push_lookup(32'hffff_ffff);
    // default route matches everything
    push_write(6'd0, 1'b1, $urandom(), 32'h0, 32'hffff_ffff, 4'hf);
    push_lookup(32'h0000_0000);
    push_lookup(32'hffff_ffff);
    // host route in the top slot
    push_write(6'd63, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 4'h0);
    push_lookup(32'hffff_ffff);
    push_lookup(32'hffff_fffe);
    // equal length tie, lowest slot wins; longer prefix beats it
    push_write(6'd5, 1'b1, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0005, 4'h5);
    push_write(6'd3, 1'b1, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_0003, 4'h3);
    push_lookup(32'h0a12_3456);
    push_write(6'd10, 1'b1, 32'h0a01_0000, 32'hffff_0000, 32'h0a01_0001, 4'ha);
    push_lookup(32'h0a01_ffff);
    push_lookup(32'h0a02_0000);
    // invalidate keeps other routes searchable
    push_write(6'd3, 1'b0, $urandom(), $urandom(), $urandom(), 4'h9);
    push_lookup(32'h0a12_3456);
    // non-contiguous mask
    push_write(6'd7, 1'b1, 32'h1200_3400, 32'hff00_ff00, 32'h1234_5678, 4'h7);
    push_lookup(32'h12ab_34cd);
    // all slots invalid again
    push_write(6'd0, 1'b0, $urandom(), $urandom(), $urandom(), 4'h0);
    push_write(6'd5, 1'b0, $urandom(), $urandom(), $urandom(), 4'h0);
    push_write(6'd7, 1'b0, $urandom(), $urandom(), $urandom(), 4'h0);
    push_write(6'd10, 1'b0, $urandom(), $urandom(), $urandom(), 4'h0);
    push_write(6'd63, 1'b0, $urandom(), $urandom(), $urandom(), 4'h0);
    push_lookup(32'h0a01_0101);
    push_lookup(32'h0000_0000);

    while (pending_q.size() < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      s    = pick_live_slot();
      if (pick < 45) begin
        if (s >= 0 && $urandom_range(0, 9) < 7)
          addr = (plan_dest[s] & plan_mask[s]) | ($urandom() & ~plan_mask[s]);
        else if ($urandom_range(0, 19) == 0)
          addr = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
        else
          addr = $urandom();
        push_lookup(addr);
      end else if (pick < 85) begin
        mask = random_mask();
        if (s >= 0 && $urandom_range(0, 6) == 0) mask = plan_mask[s];
        if (s >= 0 && $urandom_range(0, 1) == 0)
          dest = (plan_dest[s] & plan_mask[s]) | ($urandom() & ~plan_mask[s]);
        else
          dest = $urandom();
        push_write(6'($urandom_range(0, 63)), 1'b1, dest, mask, $urandom(),
                   4'($urandom_range(0, 15)));
      end else if (pick < 95) begin
        push_write(6'($urandom_range(0, 63)), 1'b0, $urandom(), $urandom(), $urandom(),
                   4'($urandom_range(0, 15)));
      end else if (pick < 96) begin
        base = $urandom_range(0, lpm_pkg::ENTRIES - 8);
        for (int k = 0; k < 8; k++) begin
          push_write(6'(base + k), 1'b0, $urandom(), $urandom(), $urandom(),
                     4'($urandom_range(0, 15)));
        end
      end else begin
        it.kind             = 1'($urandom_range(0, 1));
        it.slot_index       = 6'($urandom_range(0, 63));
        it.slot_valid       = 1'($urandom_range(0, 1));
        it.route_dest_in    = $urandom();
        it.route_mask_in    = $urandom();
        it.route_gateway_in = $urandom();
        it.route_iface_in   = 4'($urandom_range(0, 15));
        it.lookup_addr      = $urandom();
        push_item(it);
      end
    end
    total_items = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tx_cnt < total_items) @(posedge clk_i);
    while (expected_routes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // driver: one transfer per item, random gap after each
  always @(posedge clk_i or negedge rst_ni) begin : drive
    int w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait    <= 0;
    end else if (in_fire) begin
      route_table_apply(in_i);
      tx_cnt <= tx_cnt + 1;
      w = (tx_cnt % 200 >= 150) ? 0 : $urandom_range(0, MAX_WAIT);
      if (w == 0 && pending_q.size() != 0) begin
        in_i <= pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        tx_wait    <= w;
      end
    end else if (!in_valid_i) begin
      if (tx_wait > 1) begin
        tx_wait <= tx_wait - 1;
      end else if (pending_q.size() != 0) begin
        in_i       <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        tx_wait    <= 0;
      end
    end
  end

  // monitor: checks each result, then stalls for a random count
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
    end else if (out_fire) begin
      check_result(out_o);
      rx_cnt <= rx_cnt + 1;
      w = (rx_cnt % 60 >= 45) ? 0 : $urandom_range(0, MAX_WAIT);
      // one long hold so the block backs up into its input
      if (rx_cnt == HOLD_AT) w = LONG_HOLD;
      rx_hold     <= w;
      out_stall_i <= (w != 0);
    end else begin
      if (rx_hold != 0) rx_hold <= rx_hold - 1;
      out_stall_i <= (rx_hold > 1);
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
